/* rtl/ucbe_pkg.sv */
// ----------------------------------------------------------------------------
// ucbe_pkg
// Types, constants and helper functions shared by the bigram emitter.
// ----------------------------------------------------------------------------
package ucbe_pkg;

  localparam int RUN_MAX = 9;
  localparam int CNT_W   = $clog2(RUN_MAX + 1);

  localparam logic [7:0] BOM_B0     = 8'hEF;
  localparam logic [7:0] BOM_B1     = 8'hBB;
  localparam logic [7:0] BOM_B2     = 8'hBF;
  localparam logic [7:0] LEAD4_MIN  = 8'hF0;
  localparam logic [7:0] LEAD3_MIN  = 8'hE0;
  localparam logic [7:0] LEAD2_MIN  = 8'hC0;
  localparam logic [7:0] SPACE_CHAR = 8'h20;

  typedef struct packed {
    logic            char_in_progress;
    logic [3:0][7:0] current_char_bytes;
    logic [2:0]      current_char_length;
    logic [1:0]      current_byte_position;
    logic [3:0][7:0] previous_char_bytes;
    logic [2:0]      previous_char_length;
    logic            first_char_pending;
    logic            bigram_seen;
    logic [1:0]      bom_count;
  } ucbe_state_t;

  localparam ucbe_state_t STATE_RESET = '{
    char_in_progress:      1'b0,
    current_char_bytes:    32'h0,
    current_char_length:   3'd0,
    current_byte_position: 2'd0,
    previous_char_bytes:   32'h0,
    previous_char_length:  3'd0,
    first_char_pending:    1'b1,
    bigram_seen:           1'b0,
    bom_count:             2'd0
  };

  typedef struct packed {
    logic [RUN_MAX-1:0][7:0] bytes;
    logic [CNT_W-1:0]        count;
  } ucbe_run_t;

  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] n;
    if (b >= LEAD4_MIN) n = 3'd4;
    else if (b >= LEAD3_MIN) n = 3'd3;
    else if (b >= LEAD2_MIN) n = 3'd2;
    else n = 3'd1;
    return n;
  endfunction

  // Restore the state left by re-feeding n held byte-order-mark bytes.
  function automatic ucbe_state_t replay_state(input ucbe_state_t s, input logic [1:0] n);
    ucbe_state_t r;
    r = s;
    r.bom_count          = 2'd0;
    r.first_char_pending = 1'b0;
    if (n != 2'd0) begin
      r.char_in_progress      = 1'b1;
      r.current_char_length   = 3'd3;
      r.current_char_bytes    = {24'h0, BOM_B0};
      r.current_byte_position = 2'd1;
    end
    if (n >= 2'd2) begin
      r.current_char_bytes    = {16'h0, BOM_B1, BOM_B0};
      r.current_byte_position = 2'd2;
    end
    return r;
  endfunction

  // Lay out a_len bytes of a, b_len bytes of b and a closing space.
  function automatic ucbe_run_t build_run(input logic [3:0][7:0] a, input logic [2:0] a_len,
                                          input logic [3:0][7:0] b, input logic [2:0] b_len);
    ucbe_run_t        r;
    logic [CNT_W-1:0] ab_len;
    logic [CNT_W-1:0] off;
    logic [CNT_W-1:0] kk;
    ab_len  = CNT_W'(a_len) + CNT_W'(b_len);
    r.count = ab_len + CNT_W'(1);
    for (int k = 0; k < RUN_MAX; k++) begin
      kk  = CNT_W'(k);
      off = kk - CNT_W'(a_len);
      if (kk < CNT_W'(a_len)) r.bytes[k] = a[kk[1:0]];
      else if (kk < ab_len) r.bytes[k] = b[off[1:0]];
      else if (kk == ab_len) r.bytes[k] = SPACE_CHAR;
      else r.bytes[k] = 8'h00;
    end
    return r;
  endfunction

endpackage

/* rtl/ucbe_if.sv */
// ----------------------------------------------------------------------------
// ucbe_in_if / ucbe_out_if
// Valid/ready channels for string bytes in and bigram text out.
// ----------------------------------------------------------------------------
interface ucbe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_string;

  modport source (output valid, output in_byte, output end_of_string, input ready);
  modport sink (input valid, input in_byte, input end_of_string, output ready);
endinterface

interface ucbe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;

  modport source (output valid, output out_byte, output last_of_run, input ready);
  modport sink (input valid, input out_byte, input last_of_run, output ready);
endinterface

/* rtl/utf8_char_bigram_emitter.sv */
// ----------------------------------------------------------------------------
// utf8_char_bigram_emitter
// Splits a UTF-8 byte string into characters and emits space-ended bigrams,
// or the lone character of a string that forms no bigram.
//
//   channel       dir  payload                      handshake
//   byte_stream   in   in_byte[7:0], end_of_string  valid/ready
//   token_stream  out  out_byte[7:0], last_of_run   valid/ready
//
// One input word is taken per cycle when the buffer is free; its 0..9-word run is
// registered in the same cycle and leaves one word per cycle while ready is high.
// A non-empty run holds the input side until its last word is taken.
// Reset is synchronous; after reset the block waits at string start.
// ----------------------------------------------------------------------------
module utf8_char_bigram_emitter (
  input logic       clk,
  input logic       rst,
  ucbe_in_if.sink   byte_stream,
  ucbe_out_if.source token_stream
);
  import ucbe_pkg::*;

  ucbe_run_t run;
  logic      in_ready;
  logic      accept;

  assign byte_stream.ready = in_ready;
  assign accept            = byte_stream.valid && in_ready;

  ucbe_core u_core (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .in_byte       (byte_stream.in_byte),
    .end_of_string (byte_stream.end_of_string),
    .run           (run)
  );

  ucbe_out_buf u_out_buf (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .run         (run),
    .out_ready   (token_stream.ready),
    .in_ready    (in_ready),
    .out_valid   (token_stream.valid),
    .out_byte    (token_stream.out_byte),
    .last_of_run (token_stream.last_of_run)
  );

endmodule

/* rtl/ucbe_core.sv */
// ----------------------------------------------------------------------------
// ucbe_core
// Character splitting, byte-order-mark strip and bigram run assembly.
// ----------------------------------------------------------------------------
module ucbe_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [7:0]          in_byte,
  input  logic                end_of_string,
  output ucbe_pkg::ucbe_run_t run
);
  import ucbe_pkg::*;

  ucbe_state_t st;
  ucbe_state_t st_next;

  ucbe_state_t     s0;
  ucbe_state_t     s1;
  logic            do_feed;
  logic            complete;
  logic            fire;
  logic            lone;
  logic [7:0]      bom_exp;
  logic [1:0]      p;
  logic [2:0]      pos_n;
  logic [3:0][7:0] a_bytes;
  logic [2:0]      a_len;
  logic [3:0][7:0] b_bytes;
  logic [2:0]      b_len;
  ucbe_run_t       built;

  always_comb begin
    s0      = st;
    do_feed = 1'b0;
    unique case (st.bom_count)
      2'd0:    bom_exp = BOM_B0;
      2'd1:    bom_exp = BOM_B1;
      default: bom_exp = BOM_B2;
    endcase
    if (st.first_char_pending) begin
      if (in_byte == bom_exp) begin
        if (st.bom_count >= 2'd2) begin
          s0.first_char_pending = 1'b0;
          s0.bom_count          = 2'd0;
        end else begin
          s0.bom_count = st.bom_count + 2'd1;
          if (end_of_string) s0 = replay_state(st, st.bom_count + 2'd1);
        end
      end else begin
        s0      = replay_state(st, st.bom_count);
        do_feed = 1'b1;
      end
    end else begin
      do_feed = 1'b1;
    end

    s1       = s0;
    complete = 1'b0;
    fire     = 1'b0;
    p        = s0.current_byte_position;
    pos_n    = {1'b0, p} + 3'd1;
    if (do_feed) begin
      if (s0.char_in_progress) begin
        s1.current_char_bytes[p] = in_byte;
        if (pos_n >= s0.current_char_length) complete = 1'b1;
        else s1.current_byte_position = pos_n[1:0];
      end else begin
        s1.current_char_length   = lead_len(in_byte);
        s1.current_char_bytes    = {24'h0, in_byte};
        s1.current_byte_position = 2'd1;
        if (s1.current_char_length == 3'd1) complete = 1'b1;
        else s1.char_in_progress = 1'b1;
      end
    end
    b_bytes = s1.current_char_bytes;
    b_len   = s1.current_char_length;
    if (complete) begin
      if (s0.previous_char_length != 3'd0) begin
        fire           = 1'b1;
        s1.bigram_seen = 1'b1;
      end
      s1.previous_char_bytes   = s1.current_char_bytes;
      s1.previous_char_length  = s1.current_char_length;
      s1.char_in_progress      = 1'b0;
      s1.current_byte_position = 2'd0;
    end

    lone    = 1'b0;
    a_bytes = s0.previous_char_bytes;
    a_len   = s0.previous_char_length;
    st_next = s1;
    if (end_of_string) begin
      st_next = STATE_RESET;
      if (!s1.bigram_seen) begin
        if (s1.previous_char_length != 3'd0) begin
          lone    = 1'b1;
          a_bytes = s1.previous_char_bytes;
          a_len   = s1.previous_char_length;
        end else if (s1.char_in_progress && s1.current_byte_position != 2'd0) begin
          lone    = 1'b1;
          a_bytes = s1.current_char_bytes;
          a_len   = {1'b0, s1.current_byte_position};
        end
      end
    end
    if (lone) b_len = 3'd0;

    built = build_run(a_bytes, a_len, b_bytes, b_len);
    run   = built;
    if (!(fire || lone)) run.count = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= STATE_RESET;
    end else if (accept) begin
      st <= st_next;
    end
  end

  a_bom_range: assert property (@(posedge clk) disable iff (rst) st.bom_count <= 2'd2)
    else $error("bom match count out of range");
  a_seen_done: assert property (@(posedge clk) disable iff (rst)
    st.bigram_seen |-> !st.first_char_pending)
    else $error("bigram formed while still at string start");
  a_pos_ok: assert property (@(posedge clk) disable iff (rst)
    st.char_in_progress |-> (st.current_byte_position != 2'd0 &&
                             {1'b0, st.current_byte_position} < st.current_char_length))
    else $error("byte position inconsistent with character length");

endmodule

/* rtl/ucbe_out_buf.sv */
// ----------------------------------------------------------------------------
// ucbe_out_buf
// Result register holding one run; shifts out one word per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module ucbe_out_buf (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  ucbe_pkg::ucbe_run_t run,
  input  logic                out_ready,
  output logic                in_ready,
  output logic                out_valid,
  output logic [7:0]          out_byte,
  output logic                last_of_run
);
  import ucbe_pkg::*;

  logic [RUN_MAX-1:0][7:0] data;
  logic [CNT_W-1:0]        rem;
  logic                    take;

  assign out_valid   = (rem != '0);
  assign take        = out_valid && out_ready;
  assign in_ready    = (rem == '0) || (rem == CNT_W'(1) && out_ready);
  assign out_byte    = data[0];
  assign last_of_run = (rem == CNT_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= '0;
    end else if (accept) begin
      rem <= run.count;
    end else if (take) begin
      rem <= rem - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      data <= run.bytes;
    end else if (take) begin
      data <= {8'h00, data[RUN_MAX-1:1]};
    end
  end

  a_rem_max: assert property (@(posedge clk) disable iff (rst) rem <= CNT_W'(RUN_MAX))
    else $error("run length exceeds buffer");
  a_load: assert property (@(posedge clk) disable iff (rst)
    accept |=> rem == $past(run.count))
    else $error("run not loaded on accept");
  a_no_clobber: assert property (@(posedge clk) disable iff (rst)
    accept |-> (rem == '0 || (rem == CNT_W'(1) && take)))
    else $error("accepted while undelivered words remain");

endmodule
